[rtl/afl_pkg.sv]
// shared types and constants for the audio frame level meter
// no dependencies; every other file imports this package
package afl_pkg;

    localparam int RAW_W     = 32;
    localparam int PCM_W     = 16;
    localparam int THR_W     = 24;
    localparam int SHIFT_W   = 5;
    localparam int LEN_W     = 11;
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_SHIFT = 1'd1;

    localparam logic [THR_W-1:0]   THR_RESET   = 24'd0;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd14;

    // full 16x16 product width, and bits needed by the largest square (2^30)
    localparam int SQ_W     = 32;
    localparam int MAG_SQ_W = 31;

    // mean square is scaled by 2^16 so the root comes out in Q16.8
    localparam int FRAC_W     = 16;
    // mean square <= 2^30, scaled <= 2^46
    localparam int QUOT_W     = 47;
    localparam int ROOT_W     = 24;
    localparam int ROOT_STEPS = 24;
    localparam logic [QUOT_W-1:0] ROOT_BIT_START = {1'b1, {(QUOT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_slot;
        logic                    frame_end;
    } sample_t;

    typedef struct packed {
        logic signed [PCM_W-1:0] pcm_sample;
        logic                    frame_done;
        logic [PCM_W-1:0]        frame_peak;
        logic [ROOT_W-1:0]       frame_rms_q8;
        logic                    above_gate;
        logic [LEN_W-1:0]        frame_length;
    } result_t;

    // output of the shared subtract and compare unit
    typedef struct packed {
        logic              ge;
        logic [QUOT_W-1:0] diff;
    } sub_res_t;

endpackage

[rtl/audio_frame_level_meter_unit.sv]
// top level of the audio frame level meter: sample conversion, frame
// accumulation, configuration registers and result register
// depends on afl_pkg and afl_root_seq
//
// A sample that does not close a frame is taken, converted and accumulated,
// and its item appears in the result register on the next cycle. A
// sample that closes a frame (frame_end set, or the count reaching FRAME_MAX)
// holds off the input while the rms is worked out on one shared subtract and
// compare unit: a restoring divide at one quotient bit per cycle over
// 46 + clog2(FRAME_MAX + 1) bits, then a 24-step square root; the result is
// then loaded once the result register is free. A new sample is only taken
// when the result register is empty or its item leaves at the same edge.
// Configuration writes are always taken and must only be made while idle.
module audio_frame_level_meter_unit #(
    parameter int FRAME_MAX = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  afl_pkg::sample_t              sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output afl_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [afl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [afl_pkg::THR_W-1:0]     cfg_data
);
    import afl_pkg::*;

    localparam int CNT_W = $clog2(FRAME_MAX + 1);
    localparam int SUM_W = MAG_SQ_W - 1 + CNT_W;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_ROOT = 2'd1;
    localparam logic [1:0] T_LOAD = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PCM_W-1:0]   peak_reg, peak_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               result_valid_reg, result_valid_next;
    result_t            result_reg, result_next;
    logic [PCM_W-1:0]   hold_pcm_reg, hold_pcm_next;
    logic [PCM_W-1:0]   hold_peak_reg, hold_peak_next;
    logic [LEN_W-1:0]   hold_len_reg, hold_len_next;

    logic signed [RAW_W-1:0] shifted;
    logic [PCM_W-1:0]        pcm;
    logic [PCM_W-1:0]        mag;
    logic [SQ_W-1:0]         sq;
    logic [CNT_W-1:0]        cnt_inc;
    logic [PCM_W-1:0]        peak_new;
    logic [SUM_W-1:0]        sum_new;
    logic                    closes;
    logic                    accept;
    logic                    out_free;
    logic                    seq_done;
    logic [ROOT_W-1:0]       seq_root;

    assign out_free     = !result_valid_reg || result_ready;
    assign sample_ready = (state_reg == T_IDLE) && out_free;
    assign accept       = sample_valid && sample_ready;
    assign cfg_ready    = 1'b1;

    assign shifted  = sample.raw_slot >>> shift_reg;
    assign pcm      = shifted[PCM_W-1:0];
    // -32768 maps onto 32768, which still fits the unsigned field
    assign mag      = pcm[PCM_W-1] ? (~pcm + 1'b1) : pcm;
    assign sq       = mag * mag;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign peak_new = (mag > peak_reg) ? mag : peak_reg;
    assign sum_new  = sum_reg + SUM_W'(sq);
    assign closes   = sample.frame_end || (cnt_inc == CNT_W'(FRAME_MAX));

    afl_root_seq #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_root_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && closes),
        .sum   (sum_new),
        .count (cnt_inc),
        .done  (seq_done),
        .root  (seq_root)
    );

    always_comb
    begin
        state_next        = state_reg;
        thr_next          = thr_reg;
        shift_next        = shift_reg;
        cnt_next          = cnt_reg;
        peak_next         = peak_reg;
        sum_next          = sum_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        hold_pcm_next     = hold_pcm_reg;
        hold_peak_next    = hold_peak_reg;
        hold_len_next     = hold_len_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESHOLD:  thr_next   = cfg_data;
                REG_DOWN_SHIFT: shift_next = cfg_data[SHIFT_W-1:0];
                default:        ;
            endcase
        end

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    if (closes)
                    begin
                        cnt_next       = '0;
                        peak_next      = '0;
                        sum_next       = '0;
                        hold_pcm_next  = pcm;
                        hold_peak_next = peak_new;
                        hold_len_next  = LEN_W'(cnt_inc);
                        state_next     = T_ROOT;
                    end
                    else
                    begin
                        cnt_next                 = cnt_inc;
                        peak_next                = peak_new;
                        sum_next                 = sum_new;
                        result_next              = '0;
                        result_next.pcm_sample   = pcm;
                        result_valid_next        = 1'b1;
                    end
                end
            end
            T_ROOT:
            begin
                if (seq_done)
                begin
                    state_next = T_LOAD;
                end
            end
            T_LOAD:
            begin
                if (out_free)
                begin
                    result_next.pcm_sample   = hold_pcm_reg;
                    result_next.frame_done   = 1'b1;
                    result_next.frame_peak   = hold_peak_reg;
                    result_next.frame_rms_q8 = seq_root;
                    result_next.above_gate   = (seq_root >= thr_reg);
                    result_next.frame_length = hold_len_reg;
                    result_valid_next        = 1'b1;
                    state_next               = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            thr_reg          <= THR_RESET;
            shift_reg        <= SHIFT_RESET;
            cnt_reg          <= '0;
            peak_reg         <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            thr_reg          <= thr_next;
            shift_reg        <= shift_next;
            cnt_reg          <= cnt_next;
            peak_reg         <= peak_next;
            sum_reg          <= sum_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        hold_pcm_reg  <= hold_pcm_next;
        hold_peak_reg <= hold_peak_next;
        hold_len_reg  <= hold_len_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/afl_sub_unit.sv]
// shared subtract and compare unit used by the divide and square root steps
// depends on afl_pkg
module afl_sub_unit (
    input  logic [afl_pkg::QUOT_W-1:0] a,
    input  logic [afl_pkg::QUOT_W-1:0] b,
    output afl_pkg::sub_res_t          res
);
    import afl_pkg::*;

    logic [QUOT_W:0] wide_diff;

    assign wide_diff = {1'b0, a} - {1'b0, b};
    assign res.ge    = ~wide_diff[QUOT_W];
    assign res.diff  = wide_diff[QUOT_W-1:0];

endmodule

[rtl/afl_root_seq.sv]
// sequencer for the frame rms: restoring divide of the scaled square sum by
// the sample count, then bit-pair square root, both on one shared unit
// depends on afl_pkg and afl_sub_unit
module afl_root_seq #(
    parameter int SUM_W = 41,
    parameter int CNT_W = 11
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [SUM_W-1:0]           sum,
    input  logic [CNT_W-1:0]           count,
    output logic                       done,
    output logic [afl_pkg::ROOT_W-1:0] root
);
    import afl_pkg::*;

    localparam int DIV_W  = SUM_W + FRAC_W;
    localparam int STEP_W = $clog2(DIV_W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SQRT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  den_reg, den_next;
    logic [QUOT_W-1:0] v_reg, v_next;
    logic [QUOT_W-1:0] root_reg, root_next;
    logic [QUOT_W-1:0] bit_reg, bit_next;

    logic [CNT_W:0]    trial;
    logic [QUOT_W-1:0] root_bit;
    logic [QUOT_W-1:0] unit_a;
    logic [QUOT_W-1:0] unit_b;
    sub_res_t          sub;

    assign trial    = {rem_reg, div_reg[DIV_W-1]};
    assign root_bit = root_reg + bit_reg;
    assign unit_a   = (state_reg == S_DIV) ? QUOT_W'(trial) : v_reg;
    assign unit_b   = (state_reg == S_DIV) ? QUOT_W'(den_reg) : root_bit;

    afl_sub_unit u_sub (
        .a   (unit_a),
        .b   (unit_b),
        .res (sub)
    );

    always_comb
    begin
        logic [DIV_W-1:0] quot;
        quot       = {div_reg[DIV_W-2:0], sub.ge};
        state_next = state_reg;
        step_next  = step_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        v_next     = v_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DIV;
                    step_next  = STEP_W'(DIV_W - 1);
                    div_next   = {sum, {FRAC_W{1'b0}}};
                    rem_next   = '0;
                    den_next   = count;
                end
            end
            S_DIV:
            begin
                // one quotient bit per cycle
                rem_next = sub.ge ? sub.diff[CNT_W-1:0] : trial[CNT_W-1:0];
                div_next = quot;
                if (step_reg == '0)
                begin
                    state_next = S_SQRT;
                    step_next  = STEP_W'(ROOT_STEPS - 1);
                    v_next     = quot[QUOT_W-1:0];
                    root_next  = '0;
                    bit_next   = ROOT_BIT_START;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_SQRT:
            begin
                // one root bit per cycle
                if (sub.ge)
                begin
                    v_next    = sub.diff;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (step_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        v_reg    <= v_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = (state_reg == S_SQRT) && (step_reg == '0);
    assign root = root_reg[ROOT_W-1:0];

endmodule

[rtl/afl_checker.sv]
// port-level checks for the audio frame level meter, bound to the top level
// depends on afl_pkg and audio_frame_level_meter_unit
module afl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          sample_valid,
    input logic                          sample_ready,
    input afl_pkg::sample_t              sample,
    input logic                          result_valid,
    input logic                          result_ready,
    input afl_pkg::result_t              result,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [afl_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [afl_pkg::THR_W-1:0]     cfg_data
);
    import afl_pkg::*;

    // a stalled result item holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result item changed while stalled");

    // open frame items carry no summary
    a_open_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.frame_done |->
            result.frame_peak == '0 && result.frame_rms_q8 == '0 &&
            !result.above_gate && result.frame_length == '0)
        else $error("summary fields set on an open frame item");

    // a closed frame has bounded peak and rms values
    a_closed_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_done |->
            result.frame_peak <= 16'd32768 &&
            result.frame_rms_q8 <= 24'd8388608)
        else $error("frame summary out of range");

    // peak and rms are both zero or both nonzero on a closed frame
    a_peak_rms_agree: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_done |->
            ((result.frame_peak == '0) == (result.frame_rms_q8 == '0)))
        else $error("peak and rms disagree on silence");

endmodule

bind audio_frame_level_meter_unit afl_checker u_afl_checker (.*);
